@@ src/c2p_pkg.sv @@
package c2p_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int ITERATIONS  = 16;
	localparam int GUARD_BITS  = 16;

	localparam int XW  = COORD_WIDTH + GUARD_BITS + 3;
	localparam int ZW  = 26;
	localparam int HW  = 17;
	localparam int IW  = $clog2(ITERATIONS);
	localparam int MW  = XW - 1;
	localparam int ML  = MW / 2;
	localparam int MH  = MW - ML;
	localparam int RS  = 32 + GUARD_BITS;
	localparam int SW  = MW + 33;

	localparam int IN_TW  = 8 * ((2 * COORD_WIDTH + 7) / 8);
	localparam int OUT_TW = 8 * ((COORD_WIDTH + HW + 7) / 8);

	localparam int DEG90  = 23040;
	localparam int DEG180 = 46080;

	function automatic logic [31:0] gain_q32(input int n);
		logic [31:0] g;
		case (n)
			8:       g = 32'd2608158027;
			9:       g = 32'd2608138129;
			10:      g = 32'd2608133154;
			11:      g = 32'd2608131911;
			12:      g = 32'd2608131600;
			13:      g = 32'd2608131522;
			14:      g = 32'd2608131502;
			15:      g = 32'd2608131498;
			default: g = 32'd2608131496;
		endcase
		return g;
	endfunction

	localparam logic [31:0] GAIN = gain_q32(ITERATIONS);

	function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
		logic signed [ZW-1:0] a;
		case (i)
			5'd0:    a = ZW'(2949120);
			5'd1:    a = ZW'(1740967);
			5'd2:    a = ZW'(919879);
			5'd3:    a = ZW'(466945);
			5'd4:    a = ZW'(234379);
			5'd5:    a = ZW'(117304);
			5'd6:    a = ZW'(58666);
			5'd7:    a = ZW'(29335);
			5'd8:    a = ZW'(14668);
			5'd9:    a = ZW'(7334);
			5'd10:   a = ZW'(3667);
			5'd11:   a = ZW'(1833);
			5'd12:   a = ZW'(917);
			5'd13:   a = ZW'(458);
			5'd14:   a = ZW'(229);
			5'd15:   a = ZW'(115);
			5'd16:   a = ZW'(57);
			5'd17:   a = ZW'(29);
			5'd18:   a = ZW'(14);
			5'd19:   a = ZW'(7);
			5'd20:   a = ZW'(4);
			5'd21:   a = ZW'(2);
			5'd22:   a = ZW'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

	typedef struct packed {
		logic                    valid;
		logic                    x_neg;
		logic                    y_neg;
		logic                    x_zero;
		logic                    y_zero;
		logic [COORD_WIDTH-1:0]  dist_sp;
		logic signed [XW-1:0]    x;
		logic signed [XW-1:0]    y;
		logic signed [ZW-1:0]    z;
	} c2p_beat_t;

endpackage

@@ src/c2p_cell.sv @@
module c2p_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ce,
	input  logic [c2p_pkg::IW-1:0] idx,
	input  c2p_pkg::c2p_beat_t  d,
	output c2p_pkg::c2p_beat_t  q
);
	import c2p_pkg::*;

	c2p_beat_t nx;
	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	logic signed [ZW-1:0] ang;

	always_comb begin
		dx  = d.y >>> idx;
		dy  = d.x >>> idx;
		ang = atan_q16(5'(idx));
		nx  = d;
		if (!d.y[XW-1]) begin
			nx.x = d.x + dx;
			nx.y = d.y - dy;
			nx.z = d.z + ang;
		end else begin
			nx.x = d.x - dx;
			nx.y = d.y + dy;
			nx.z = d.z - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (ce) begin
			q <= nx;
		end
	end

endmodule

@@ src/c2p_post.sv @@
module c2p_post (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             ce,
	input  c2p_pkg::c2p_beat_t               d,
	output logic                             valid_s2,
	output logic [c2p_pkg::COORD_WIDTH-1:0]  distance_s2,
	output logic signed [c2p_pkg::HW-1:0]    heading_s2
);
	import c2p_pkg::*;

	logic [MW-1:0]          ux;
	logic [ML+31:0]         pl_c;
	logic [MH+31:0]         ph_c;
	logic signed [ZW-1:0]   zr;
	logic signed [HW:0]     a;
	logic signed [HW:0]     hd;
	logic                   y_pos;

	logic                   valid_s1;
	logic                   sp_s1;
	logic                   x_zero_s1;
	logic                   x_neg_s1;
	logic                   y_neg_s1;
	logic [COORD_WIDTH-1:0] dist_sp_s1;
	logic [ML+31:0]         pl_s1;
	logic [MH+31:0]         ph_s1;
	logic signed [HW-1:0]   head_s1;

	logic [SW-1:0]          sum;
	logic [SW-RS-1:0]       qd;
	logic [COORD_WIDTH-1:0] dist_c;

	always_comb begin
		ux    = d.x[XW-1] ? '0 : d.x[MW-1:0];
		pl_c  = ux[ML-1:0] * GAIN;
		ph_c  = ux[MW-1:ML] * GAIN;
		zr    = d.z + ZW'(128);
		a     = zr[ZW-1:8];
		y_pos = !d.y_neg && !d.y_zero;
		if (a < 0) begin
			a = '0;
		end else if (a > DEG90) begin
			a = (HW+1)'(DEG90);
		end
		if (d.x_zero) begin
			hd = y_pos ? (HW+1)'(DEG90) : -(HW+1)'(DEG90);
		end else if (d.y_zero) begin
			hd = d.x_neg ? (HW+1)'(DEG180) : '0;
		end else if (!d.x_neg && !d.y_neg) begin
			hd = a;
		end else if (d.x_neg && !d.y_neg) begin
			hd = (HW+1)'(DEG180) - a;
		end else if (!d.x_neg) begin
			hd = -a;
		end else begin
			hd = a - (HW+1)'(DEG180);
		end
	end

	always_comb begin
		sum    = SW'({ph_s1, {ML{1'b0}}}) + SW'(pl_s1) + (SW'(1) << (RS - 1));
		qd     = sum[SW-1:RS];
		dist_c = (|qd[SW-RS-1:COORD_WIDTH]) ? '1 : qd[COORD_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= d.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sp_s1       <= d.x_zero || d.y_zero;
			x_zero_s1   <= d.x_zero;
			x_neg_s1    <= d.x_neg;
			y_neg_s1    <= d.y_neg;
			dist_sp_s1  <= d.dist_sp;
			pl_s1       <= pl_c;
			ph_s1       <= ph_c;
			head_s1     <= hd[HW-1:0];
			heading_s2  <= head_s1;
			distance_s2 <= sp_s1 ? dist_sp_s1 : dist_c;
		end
	end

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (heading_s2 >= -DEG180) && (heading_s2 <= DEG180))
		else $error("heading out of range");

	a_x_zero_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(ce && valid_s1 && x_zero_s1) |=> (heading_s2 == DEG90) || (heading_s2 == -DEG90))
		else $error("zero x did not give a vertical heading");

	a_second_quad: assert property (@(posedge clk) disable iff (!arst_n)
		(ce && valid_s1 && !sp_s1 && x_neg_s1 && !y_neg_s1) |=>
			(heading_s2 >= DEG90) && (heading_s2 <= DEG180))
		else $error("second quadrant heading wrong");

	a_fourth_quad: assert property (@(posedge clk) disable iff (!arst_n)
		(ce && valid_s1 && !sp_s1 && !x_neg_s1 && y_neg_s1) |=>
			(heading_s2 <= 0) && (heading_s2 >= -DEG90))
		else $error("fourth quadrant heading wrong");

endmodule

@@ src/cartesian_to_polar_degrees.sv @@
// Rectangular to polar conversion. Each input beat carries a signed Q.8 pair
// (x east, y north); each output beat carries the Q.8 distance, rounded and
// saturated, and the Q.8 heading in degrees, east 0, north +90, in [-180, 180].
// The origin gives -90. One beat is accepted every cycle while the output is
// not stalled. The pipeline is one input register, one vectoring cell per
// iteration, one stage for the split gain multiply and heading restore, and
// one output register for the rounding add. A stalled output holds the
// whole pipeline.
module cartesian_to_polar_degrees (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// x_coord, y_coord
	input  logic [c2p_pkg::IN_TW-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// distance, heading, zero pad
	output logic [c2p_pkg::OUT_TW-1:0]    m_tdata
);
	import c2p_pkg::*;

	logic                          ce;
	logic signed [COORD_WIDTH-1:0] x_in;
	logic signed [COORD_WIDTH-1:0] y_in;
	logic [COORD_WIDTH-1:0]        ax;
	logic [COORD_WIDTH-1:0]        ay;
	c2p_beat_t                     in_q;
	c2p_beat_t                     chain [ITERATIONS+1];
	logic [COORD_WIDTH-1:0]        distance;
	logic signed [HW-1:0]          heading;

	assign ce       = !m_tvalid || m_tready;
	assign s_tready = ce;
	assign x_in     = s_tdata[COORD_WIDTH-1:0];
	assign y_in     = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
	assign ax       = x_in[COORD_WIDTH-1] ? (~x_in + 1'b1) : x_in;
	assign ay       = y_in[COORD_WIDTH-1] ? (~y_in + 1'b1) : y_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_q <= '0;
		end else if (ce) begin
			in_q.valid   <= s_tvalid;
			in_q.x_neg   <= x_in[COORD_WIDTH-1];
			in_q.y_neg   <= y_in[COORD_WIDTH-1];
			in_q.x_zero  <= (x_in == '0);
			in_q.y_zero  <= (y_in == '0);
			in_q.dist_sp <= (x_in == '0) ? ay : ax;
			in_q.x       <= {3'b000, ax, {GUARD_BITS{1'b0}}};
			in_q.y       <= {3'b000, ay, {GUARD_BITS{1'b0}}};
			in_q.z       <= '0;
		end
	end

	assign chain[0] = in_q;

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
		c2p_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ce     (ce),
			.idx    (IW'(i)),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	c2p_post u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.ce          (ce),
		.d           (chain[ITERATIONS]),
		.valid_s2    (m_tvalid),
		.distance_s2 (distance),
		.heading_s2  (heading)
	);

	assign m_tdata = OUT_TW'({heading, distance});

endmodule

@@ sim/cartesian_to_polar_degrees_chk.sv @@
`timescale 1ns / 1ps

module cartesian_to_polar_degrees_chk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	// x_coord, y_coord
	input  logic [c2p_pkg::IN_TW-1:0]  s_tdata,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	// distance, heading, zero pad
	input  logic [c2p_pkg::OUT_TW-1:0] m_tdata,
	output int                         errors,
	output int                         pending
);

	localparam int CW = c2p_pkg::COORD_WIDTH;
	localparam int HW = c2p_pkg::HW;
	localparam int GUARD = 16;
	localparam longint RIGHT_ANGLE = 23040;
	localparam longint STRAIGHT_ANGLE = 46080;
	localparam int STEPS = (c2p_pkg::ITERATIONS < 8) ? 8 :
		((c2p_pkg::ITERATIONS > 24) ? 24 : c2p_pkg::ITERATIONS);

	typedef struct packed {
		logic [CW-1:0]        distance;
		logic signed [HW-1:0] heading;
	} polar_t;

	longint atan_deg_q16 [0:23] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	longint unsigned inv_gain_q32 [0:16] = '{
		64'd2608158027, 64'd2608138129, 64'd2608133154, 64'd2608131911,
		64'd2608131600, 64'd2608131522, 64'd2608131502, 64'd2608131498,
		64'd2608131496, 64'd2608131496, 64'd2608131496, 64'd2608131496,
		64'd2608131496, 64'd2608131496, 64'd2608131496, 64'd2608131496,
		64'd2608131496
	};

	polar_t polar_q [$];
	polar_t want;
	logic [CW-1:0] got_dist;
	logic signed [HW-1:0] got_head;
	int err_count = 0;

	function automatic polar_t polar_of(input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y);
		longint sx, sy, cx, cy, dx, dy, z, a, head;
		longint unsigned ux, xh, xl, p, rho, k;
		polar_t r;
		sx = x;
		sy = y;
		cx = (sx < 0) ? -sx : sx;
		cy = (sy < 0) ? -sy : sy;
		if (sx == 0) begin
			head = (sy > 0) ? RIGHT_ANGLE : -RIGHT_ANGLE;
			rho = cy;
		end else if (sy == 0) begin
			head = (sx > 0) ? 0 : STRAIGHT_ANGLE;
			rho = cx;
		end else begin
			cx = cx <<< GUARD;
			cy = cy <<< GUARD;
			z = 0;
			for (int i = 0; i < STEPS; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy >= 0) begin
					cx = cx + dx;
					cy = cy - dy;
					z = z + atan_deg_q16[i];
				end else begin
					cx = cx - dx;
					cy = cy + dy;
					z = z - atan_deg_q16[i];
				end
			end
			a = (z + 128) >>> 8;
			if (a < 0)
				a = 0;
			if (a > RIGHT_ANGLE)
				a = RIGHT_ANGLE;
			if (sx > 0 && sy > 0)
				head = a;
			else if (sx < 0 && sy > 0)
				head = STRAIGHT_ANGLE - a;
			else if (sx > 0)
				head = -a;
			else
				head = -STRAIGHT_ANGLE + a;
			// split the gain product to keep it inside 64 bits
			ux = (cx < 0) ? 64'd0 : cx;
			k = inv_gain_q32[STEPS-8];
			xh = ux >> 25;
			xl = ux & ((64'd1 << 25) - 64'd1);
			p = xh * k + ((xl * k) >> 25);
			rho = (p + (64'd1 << 22)) >> 23;
		end
		if (rho > ((64'd1 << CW) - 64'd1))
			rho = (64'd1 << CW) - 64'd1;
		r.distance = rho[CW-1:0];
		r.heading = head[HW-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polar_q.delete();
			pending <= 0;
			errors <= 0;
		end else begin
			if (s_tvalid && s_tready)
				polar_q.push_back(polar_of(s_tdata[CW-1:0], s_tdata[2*CW-1:CW]));
			if (m_tvalid && m_tready) begin
				got_dist = m_tdata[CW-1:0];
				got_head = m_tdata[CW+HW-1:CW];
				if (polar_q.size() == 0) begin
					$display("%0t: unexpected beat: expected none, actual distance %0d heading %0d",
						$time, got_dist, got_head);
					err_count++;
				end else begin
					want = polar_q.pop_front();
					if (got_dist !== want.distance) begin
						$display("%0t: distance mismatch: expected %0d, actual %0d",
							$time, want.distance, got_dist);
						err_count++;
					end
					if (got_head !== want.heading) begin
						$display("%0t: heading mismatch: expected %0d, actual %0d",
							$time, want.heading, got_head);
						err_count++;
					end
				end
			end
			pending <= polar_q.size();
			errors <= err_count;
		end
	end

endmodule

@@ sim/cartesian_to_polar_degrees_tb.sv @@
`timescale 1ns / 1ps

module cartesian_to_polar_degrees_tb;

	localparam int CW = c2p_pkg::COORD_WIDTH;
	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] ONE = 1;
	localparam logic signed [CW-1:0] NEG_ONE = -1;
	localparam logic signed [CW-1:0] ZERO = 0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [c2p_pkg::IN_TW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [c2p_pkg::OUT_TW-1:0] m_tdata;
	int errors;
	int pending;
	int idle_pct = 0;
	int stall_pct = 0;

	cartesian_to_polar_degrees u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	cartesian_to_polar_degrees_chk u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	task automatic send_pair(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c2p_pkg::IN_TW'({y, x});
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		logic signed [CW-1:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: v = CW'($urandom);
			5, 6:          v = CW'(int'($urandom_range(1024)) - 512);
			7:             v = ZERO;
			8: begin
				case ($urandom_range(3))
					0:       v = CMAX;
					1:       v = CMIN;
					2:       v = ONE;
					default: v = NEG_ONE;
				endcase
			end
			default:       v = CW'(int'($urandom_range(131071)) - 65536);
		endcase
		return v;
	endfunction

	task automatic run_random(input int n, input int idle, input int stall);
		idle_pct = idle;
		stall_pct = stall;
		repeat (n)
			send_pair(rand_coord(), rand_coord());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pair(ZERO, ZERO);
		send_pair(ZERO, ONE);
		send_pair(ZERO, NEG_ONE);
		send_pair(ZERO, CMAX);
		send_pair(ZERO, CMIN);
		send_pair(ONE, ZERO);
		send_pair(NEG_ONE, ZERO);
		send_pair(CMAX, ZERO);
		send_pair(CMIN, ZERO);
		send_pair(ONE, ONE);
		send_pair(NEG_ONE, ONE);
		send_pair(ONE, NEG_ONE);
		send_pair(NEG_ONE, NEG_ONE);
		send_pair(CMAX, CMAX);
		send_pair(CMIN, CMIN);
		send_pair(CMIN, CMAX);
		send_pair(CMAX, CMIN);
		send_pair(CMIN, NEG_ONE);
		send_pair(CMIN, ONE);
		send_pair(CMAX, NEG_ONE);
		send_pair(ONE, CMIN);
		send_pair(NEG_ONE, CMAX);

		run_random(100, 0, 0);
		run_random(100, 85, 0);

		// hold off until the pipeline drains
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);

		run_random(100, 0, 85);
		run_random(100, 20, 20);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (c2p_pkg::ITERATIONS + 10) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("[cartesian_to_polar_degrees] OK");
		else
			$display("[cartesian_to_polar_degrees] ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("[cartesian_to_polar_degrees] ERROR");
		$finish;
	end

endmodule
